FILE: rtl/ihp_pkg.sv
`timescale 1ns / 1ps

package ihp_pkg;

	// Character codes used by the header grammar
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_5     = 8'h35;

	// Digest value length in hex digits; the count saturates one past it
	localparam int VCOUNT_W = 6;
	localparam logic [VCOUNT_W-1:0] DIGEST_DIGITS = 6'd32;

	localparam int DIGEST_W = 64;
	localparam int OUT_TDATA_W = 144;

	// Parser phase, one-hot
	typedef enum logic [8:0] {
		PH_LINE_START = 9'b000000001,
		PH_DASH1      = 9'b000000010,
		PH_DASH2      = 9'b000000100,
		PH_NAME       = 9'b000001000,
		PH_SPACES     = 9'b000010000,
		PH_VALUE      = 9'b000100000,
		PH_VALUE_STOP = 9'b001000000,
		PH_BODY_WAIT  = 9'b010000000,
		PH_BODY       = 9'b100000000
	} phase_t;

	// Progress of matching the header name against "MD5", one-hot
	typedef enum logic [5:0] {
		NM_START = 6'b000001,
		NM_M     = 6'b000010,
		NM_MD    = 6'b000100,
		NM_MD5   = 6'b001000,
		NM_ENDED = 6'b010000,
		NM_MISS  = 6'b100000
	} name_match_t;

	typedef enum logic [1:0] {
		VERDICT_OK     = 2'd0,
		VERDICT_SYNTAX = 2'd1,
		VERDICT_NOBODY = 2'd2,
		VERDICT_DIGEST = 2'd3
	} verdict_t;

	// One result transaction
	typedef struct packed {
		logic [7:0]          body_byte;
		logic                body_valid;
		logic                done_res;
		verdict_t            verdict;
		logic [DIGEST_W-1:0] digest_high;
		logic [DIGEST_W-1:0] digest_low;
	} result_t;

	// Advance the name matcher by one name character
	function automatic name_match_t match_step(input name_match_t m, input logic [7:0] b);
		name_match_t r;
		case (m)
			NM_START: r = (b == CH_M) ? NM_M : NM_MISS;
			NM_M:     r = (b == CH_D) ? NM_MD : NM_MISS;
			NM_MD:    r = (b == CH_5) ? NM_MD5 : NM_MISS;
			NM_MD5:   r = (b == CH_NUL) ? NM_ENDED : NM_MISS;
			NM_ENDED: r = NM_ENDED;
			default:  r = NM_MISS;
		endcase
		return r;
	endfunction

	// Decode one hex digit; bit 4 flags a valid digit
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

FILE: rtl/image_header_parser_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                         Contents
// s_*      in   s_tvalid s_tready s_tdata       data_byte
//               s_tuser s_tlast                 has_byte, last_item
// m_*      out  m_tvalid m_tready m_tdata       body_byte, verdict, digest_high, digest_low
//               m_tuser m_tlast                 body_valid, done_res
//
// One input transaction per cycle while s_tready is high; each gives one result transaction.
// The parser state updates in the same cycle the byte is taken; the result register
// and a one-entry skid buffer keep input flowing while the output side stalls.
// s_tready drops only when both the result register and the skid buffer are full.
// arst_n clears parser state and both output stages; no clearing pass is needed.

module image_header_parser_top import ihp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] data_byte
	input  logic                   s_tuser,   // [0] has_byte
	input  logic                   s_tlast,   // last_item
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] body_byte, [9:8] verdict,
	                                          // [73:10] digest_high, [137:74] digest_low,
	                                          // [143:138] zero
	output logic                   m_tuser,   // [0] body_valid
	output logic                   m_tlast    // done_res
);

	logic    accept;
	result_t step_res;
	result_t out_res;

	assign accept = s_tvalid && s_tready;

	// Parse one byte per accepted transaction
	ihp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_tdata),
		.has_byte  (s_tuser),
		.last_item (s_tlast),
		.res       (step_res)
	);

	// Hold results for the master side
	ihp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_res    (step_res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the result fields onto the stream
	assign m_tdata = {6'd0, out_res.digest_low, out_res.digest_high,
	                  out_res.verdict, out_res.body_byte};
	assign m_tuser = out_res.body_valid;
	assign m_tlast = out_res.done_res;

endmodule

FILE: rtl/ihp_parser.sv
`timescale 1ns / 1ps

module ihp_parser import ihp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       last_item,
	output result_t    res
);

	phase_t              phase_q, phase_d;
	name_match_t         nm_q, nm_d;
	logic [VCOUNT_W-1:0] vcount_q, vcount_d;
	logic [DIGEST_W-1:0] dig_hi_q, dig_hi_d;
	logic [DIGEST_W-1:0] dig_lo_q, dig_lo_d;
	logic                seen_q, seen_d;
	logic                bad_q, bad_d;
	logic                body_q, body_d;
	logic                synerr_q, synerr_d;

	logic       do_value;
	logic       do_eol;
	logic       is_md5;
	logic [4:0] hex;
	logic [3:0] nib;
	verdict_t   verdict;

	assign is_md5 = (nm_q == NM_MD5) || (nm_q == NM_ENDED);
	assign hex    = hex_decode(data_byte);
	// Digit n lands in nibble 15 - n of its word, first digit most significant
	assign nib    = ~vcount_q[3:0];

	// Compute the next parser state and the result for this byte
	always_comb begin
		phase_d  = phase_q;
		nm_d     = nm_q;
		vcount_d = vcount_q;
		dig_hi_d = dig_hi_q;
		dig_lo_d = dig_lo_q;
		seen_d   = seen_q;
		bad_d    = bad_q;
		body_d   = body_q;
		synerr_d = synerr_q;
		do_value = 1'b0;
		do_eol   = 1'b0;
		verdict  = VERDICT_OK;
		res      = '0;

		if (has_byte && !synerr_q) begin
			case (phase_q)
				PH_LINE_START: begin
					if (data_byte == CH_COLON) begin
						synerr_d = 1'b1;
					end else if (data_byte == CH_DASH) begin
						nm_d    = NM_MISS;
						phase_d = PH_DASH1;
					end else if (data_byte != CH_NL) begin
						nm_d    = match_step(NM_START, data_byte);
						phase_d = PH_NAME;
					end
				end
				PH_DASH1, PH_DASH2, PH_NAME: begin
					if (phase_q == PH_DASH2 && data_byte == CH_NL) begin
						phase_d = PH_BODY_WAIT;
					end else if (data_byte == CH_NL) begin
						synerr_d = 1'b1;
					end else if (data_byte == CH_COLON) begin
						vcount_d = '0;
						phase_d  = PH_SPACES;
					end else if (phase_q == PH_DASH1 && data_byte == CH_DASH) begin
						phase_d = PH_DASH2;
					end else begin
						nm_d    = match_step(nm_q, data_byte);
						phase_d = PH_NAME;
					end
				end
				PH_SPACES: begin
					do_value = (data_byte != CH_SPACE);
				end
				PH_VALUE: begin
					do_value = 1'b1;
				end
				PH_VALUE_STOP: begin
					do_eol = (data_byte == CH_NL);
				end
				PH_BODY_WAIT, PH_BODY: begin
					body_d         = 1'b1;
					phase_d        = PH_BODY;
					res.body_byte  = data_byte;
					res.body_valid = 1'b1;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		// Take one value character
		if (do_value) begin
			if (data_byte == CH_NL) begin
				do_eol = 1'b1;
			end else if (data_byte == CH_NUL) begin
				phase_d = PH_VALUE_STOP;
			end else begin
				if (vcount_q < DIGEST_DIGITS && is_md5) begin
					if (!hex[4]) begin
						bad_d = 1'b1;
					end else if (!seen_q) begin
						if (vcount_q[4]) begin
							dig_lo_d[nib*4 +: 4] = hex[3:0];
						end else begin
							dig_hi_d[nib*4 +: 4] = hex[3:0];
						end
					end
				end
				if (vcount_q <= DIGEST_DIGITS) begin
					vcount_d = vcount_q + 1'b1;
				end
				phase_d = PH_VALUE;
			end
		end

		// Close a header line and check the digest header
		if (do_eol) begin
			if (is_md5) begin
				if (seen_q || vcount_q != DIGEST_DIGITS) begin
					bad_d = 1'b1;
				end else if (!bad_q) begin
					seen_d = 1'b1;
				end
			end
			phase_d = PH_LINE_START;
		end

		// Give the verdict at end of file and start over
		if (last_item) begin
			if (synerr_d) begin
				verdict = VERDICT_SYNTAX;
			end else if (!body_d) begin
				verdict = VERDICT_NOBODY;
			end else if (!seen_d || bad_d) begin
				verdict = VERDICT_DIGEST;
			end
			res.done_res = 1'b1;
			res.verdict  = verdict;
			if (verdict == VERDICT_OK) begin
				res.digest_high = dig_hi_d;
				res.digest_low  = dig_lo_d;
			end
			phase_d  = PH_LINE_START;
			nm_d     = NM_START;
			vcount_d = '0;
			dig_hi_d = '0;
			dig_lo_d = '0;
			seen_d   = 1'b0;
			bad_d    = 1'b0;
			body_d   = 1'b0;
			synerr_d = 1'b0;
		end
	end

	// Update parser state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE_START;
			nm_q     <= NM_START;
			vcount_q <= '0;
			dig_hi_q <= '0;
			dig_lo_q <= '0;
			seen_q   <= 1'b0;
			bad_q    <= 1'b0;
			body_q   <= 1'b0;
			synerr_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			nm_q     <= nm_d;
			vcount_q <= vcount_d;
			dig_hi_q <= dig_hi_d;
			dig_lo_q <= dig_lo_d;
			seen_q   <= seen_d;
			bad_q    <= bad_d;
			body_q   <= body_d;
			synerr_q <= synerr_d;
		end
	end

endmodule

FILE: rtl/ihp_out_stage.sv
`timescale 1ns / 1ps

module ihp_out_stage import ihp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  result_t in_res,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    out_valid_q;
	result_t out_res_q;
	logic    skid_valid_q;
	result_t skid_res_q;
	logic    out_free;

	// The output register can take new data when empty or being drained
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// Control: output register valid and skid valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || in_valid;
				skid_valid_q <= 1'b0;
			end else if (in_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload: refill from skid first, then from the incoming transaction
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
			end else if (in_valid) begin
				out_res_q <= in_res;
			end
		end else if (in_valid) begin
			skid_res_q <= in_res;
		end
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ihp_pkg::*;

	localparam int RANDOM_ITEMS   = 950;
	localparam int HOLD_CYCLES    = 400;
	localparam int IDLE_LIMIT     = 3000;
	localparam int SETTLE_CYCLES  = 10;

	typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	image_header_parser_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Parser state as the predictor sees it
	phase_t      cur_phase;
	name_match_t cur_match;
	logic [5:0]  digit_count;
	logic [63:0] digest_word [2];
	logic        have_digest;
	logic        digest_bad;
	logic        got_body;
	logic        syntax_bad;

	result_t     predicted_outputs [$];
	logic [7:0]  image [$];

	int          fail_count      = 0;
	int          items_sent      = 0;
	int          files_sent      = 0;
	int          results_checked = 0;
	int          verdict_tally [4];
	int          burst_left      = 0;
	bit          sender_steady   = 1'b0;
	int          marker_pct      = 0;
	int          hold_req        = 0;
	int          hold_left       = 0;
	int          idle_cycles     = 0;
	rx_mode_t    rx_mode         = RX_OPEN;
	int          rx_mode_left    = 0;
	logic [7:0]  rx_pattern      = 8'b1011_0110;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_parse_state();
		cur_phase      = PH_LINE_START;
		cur_match      = NM_START;
		digit_count    = '0;
		digest_word[0] = '0;
		digest_word[1] = '0;
		have_digest    = 1'b0;
		digest_bad     = 1'b0;
		got_body       = 1'b0;
		syntax_bad     = 1'b0;
	endfunction

	// Track how far the header name agrees with "MD5" plus an optional zero end
	function automatic name_match_t name_next(input name_match_t m, input logic [7:0] b);
		logic [7:0] want;
		case (m)
			NM_START: want = CH_M;
			NM_M:     want = CH_D;
			NM_MD:    want = CH_5;
			NM_MD5:   want = CH_NUL;
			default:  return m;
		endcase
		return (b == want) ? m.next() : NM_MISS;
	endfunction

	// Close a header line; an MD5 line must be a first, full-length digest
	function automatic void close_line();
		if (cur_match == NM_MD5 || cur_match == NM_ENDED) begin
			if (have_digest || digit_count != DIGEST_DIGITS) begin
				digest_bad = 1'b1;
			end else if (!digest_bad) begin
				have_digest = 1'b1;
			end
		end
		cur_phase = PH_LINE_START;
	endfunction

	function automatic void value_char(input logic [7:0] b);
		logic [3:0] nib;
		bit         is_hex;
		if (b == CH_NL) begin
			close_line();
			return;
		end
		if (b == CH_NUL) begin
			cur_phase = PH_VALUE_STOP;
			return;
		end
		if (digit_count < DIGEST_DIGITS && (cur_match == NM_MD5 || cur_match == NM_ENDED)) begin
			is_hex = 1'b1;
			nib    = '0;
			if (b inside {[8'h30:8'h39]}) begin
				nib = b[3:0];
			end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
				nib = b[3:0] + 4'd9;
			end else begin
				is_hex = 1'b0;
			end
			if (!is_hex) begin
				digest_bad = 1'b1;
			end else if (!have_digest) begin
				digest_word[digit_count[4]][4 * (15 - digit_count[3:0]) +: 4] = nib;
			end
		end
		// Saturate one past the digest length
		if (digit_count <= DIGEST_DIGITS) begin
			digit_count++;
		end
		cur_phase = PH_VALUE;
	endfunction

	// Advance the parser by one input transaction and return the output it must give
	function automatic result_t parse_byte(input logic [7:0] b, input logic has,
	                                       input logic last);
		result_t r;
		r = '0;
		if (has && !syntax_bad) begin
			case (cur_phase)
				PH_LINE_START: begin
					if (b == CH_COLON) begin
						syntax_bad = 1'b1;
					end else if (b == CH_DASH) begin
						cur_match = NM_MISS;
						cur_phase = PH_DASH1;
					end else if (b != CH_NL) begin
						cur_match = name_next(NM_START, b);
						cur_phase = PH_NAME;
					end
				end
				PH_DASH1, PH_DASH2, PH_NAME: begin
					if (cur_phase == PH_DASH2 && b == CH_NL) begin
						cur_phase = PH_BODY_WAIT;
					end else if (b == CH_NL) begin
						syntax_bad = 1'b1;
					end else if (b == CH_COLON) begin
						digit_count = '0;
						cur_phase   = PH_SPACES;
					end else if (cur_phase == PH_DASH1 && b == CH_DASH) begin
						cur_phase = PH_DASH2;
					end else begin
						cur_match = name_next(cur_match, b);
						cur_phase = PH_NAME;
					end
				end
				PH_SPACES: begin
					if (b != CH_SPACE) begin
						value_char(b);
					end
				end
				PH_VALUE: value_char(b);
				PH_VALUE_STOP: begin
					if (b == CH_NL) begin
						close_line();
					end
				end
				default: begin
					got_body     = 1'b1;
					cur_phase    = PH_BODY;
					r.body_byte  = b;
					r.body_valid = 1'b1;
				end
			endcase
		end
		r.done_res = last;
		if (last) begin
			if (syntax_bad) begin
				r.verdict = VERDICT_SYNTAX;
			end else if (!got_body) begin
				r.verdict = VERDICT_NOBODY;
			end else if (!have_digest || digest_bad) begin
				r.verdict = VERDICT_DIGEST;
			end else begin
				r.verdict     = VERDICT_OK;
				r.digest_high = digest_word[0];
				r.digest_low  = digest_word[1];
			end
			verdict_tally[r.verdict]++;
			clear_parse_state();
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Output side: stall pattern, checker, watchdog
	// ------------------------------------------------------------------

	// Drive ready: a requested long hold-off first, else the current stall mode
	always @(posedge clk) begin
		if (hold_left == 0 && hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 2));
				rx_mode_left = $urandom_range(20, 300);
			end
			rx_mode_left--;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 55);
				default: begin
					rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
					m_tready <= rx_pattern[0];
				end
			endcase
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
	                                    input logic [63:0] got);
		if (got !== want) begin
			$error("output %0d field %s: expected %0h, got %0h",
			       results_checked, name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin : check_outputs
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_outputs.size() == 0) begin
				$error("output %0d arrived with no prediction pending", results_checked);
				fail_count++;
			end else begin
				want = predicted_outputs.pop_front();
				check_field("body_byte",   want.body_byte,   m_tdata[7:0]);
				check_field("body_valid",  want.body_valid,  m_tuser);
				check_field("done_res",    want.done_res,    m_tlast);
				check_field("verdict",     want.verdict,     m_tdata[9:8]);
				check_field("digest_high", want.digest_high, m_tdata[73:10]);
				check_field("digest_low",  want.digest_low,  m_tdata[137:74]);
			end
			results_checked++;
		end
	end

	// End the run if neither side moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one byte in bursts with random gaps unless the sender is steady, and predict its output once taken
	task automatic send_byte(input logic [7:0] d, input logic has, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!sender_steady) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= has;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted_outputs.push_back(parse_byte(d, has, last));
		burst_left--;
		items_sent++;
		if (last) begin
			files_sent++;
		end
	endtask

	// Stop offering and hold until every predicted output has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (predicted_outputs.size() != 0) @(posedge clk);
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			image.push_back(s[i]);
		end
	endfunction

	// Push hex digits in mixed case
	function automatic void add_hex(input int n);
		int v;
		for (int i = 0; i < n; i++) begin
			v = $urandom_range(0, 15);
			if (v < 10) begin
				image.push_back(8'(8'h30 + v));
			end else if ($urandom_range(0, 1)) begin
				image.push_back(8'(8'h57 + v));
			end else begin
				image.push_back(8'(8'h37 + v));
			end
		end
	endfunction

	// Send the built image; end on its last byte or on a bare end marker
	task automatic send_image(input bit bare_end);
		logic [7:0] tail;
		if (image.size() == 0) begin
			bare_end = 1'b1;
		end
		if (!bare_end) begin
			tail = image.pop_back();
		end
		foreach (image[i]) begin
			if ($urandom_range(0, 99) < marker_pct) begin
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			send_byte(image[i], 1'b1, 1'b0);
		end
		if (bare_end) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else begin
			send_byte(tail, 1'b1, 1'b1);
		end
		image.delete();
	endtask

	function automatic void add_md5_line();
		int kind;
		int bad_at;
		kind = $urandom_range(0, 11);
		add_text("MD5");
		if (kind == 11) begin
			image.push_back(CH_NUL);
			add_text("x");
		end
		add_text(":");
		repeat ($urandom_range(0, 2)) image.push_back(CH_SPACE);
		case (kind)
			1: add_hex(31);
			2: add_hex(33);
			3: add_hex(40);
			4: add_hex(0);
			5: begin
				add_hex(32);
				bad_at = $urandom_range(1, 32);
				image[image.size() - bad_at] = 8'($urandom_range(8'h67, 8'h7A));
			end
			6: begin
				add_hex(32);
				image.push_back(CH_NUL);
				add_text("tail:x");
			end
			default: add_hex(32);
		endcase
		image.push_back(CH_NL);
	endfunction

	function automatic void add_plain_line();
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: image.push_back(CH_M);
				1: image.push_back(CH_D);
				2: image.push_back(CH_5);
				3: image.push_back(CH_DASH);
				default: image.push_back(8'($urandom_range(8'h61, 8'h7A)));
			endcase
		end
		add_text(":");
		repeat ($urandom_range(0, 2)) image.push_back(CH_SPACE);
		n = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
		repeat (n) image.push_back(8'($urandom_range(8'h21, 8'h7E)));
		image.push_back(CH_NL);
	endfunction

	function automatic logic [7:0] grammar_byte();
		case ($urandom_range(0, 9))
			0: return CH_COLON;
			1: return CH_DASH;
			2: return CH_NL;
			3: return CH_SPACE;
			4: return CH_NUL;
			5: return CH_M;
			6: return CH_D;
			7: return CH_5;
			8: return 8'($urandom_range(8'h30, 8'h46));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed images with random content, some damaged
	function automatic void build_random_image();
		int n_hdr;
		int md5_at;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) image.push_back(CH_NL);
		end
		n_hdr  = $urandom_range(0, 2);
		md5_at = $urandom_range(0, n_hdr);
		for (int i = 0; i <= n_hdr; i++) begin
			if (i == md5_at && $urandom_range(0, 9) != 0) begin
				add_md5_line();
			end else begin
				add_plain_line();
			end
		end
		if ($urandom_range(0, 15) == 0) begin
			add_md5_line();
		end
		case ($urandom_range(0, 19))
			0: add_text("--x\n");
			1: add_text("-\n");
			2: ;
			default: add_text("--\n");
		endcase
		repeat ($urandom_range(0, 16)) image.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0) begin
			image[$urandom_range(0, image.size() - 1)] = grammar_byte();
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed_images();
		// Colon at a line start, then bytes that must be ignored
		add_text(":abc\n--\nX");
		send_image(1'b1);
		// Newline inside a name, and after a single dash
		add_text("ab\n--\nQ");
		send_image(1'b0);
		add_text("-\n");
		send_image(1'b1);
		// Lone end marker; empty lines and delimiter without a body
		send_image(1'b1);
		add_text("\n\n--\n");
		send_image(1'b1);
		// Body with extreme and grammar bytes, but no digest header
		add_text("--\n");
		image.push_back(8'h00);
		image.push_back(8'hFF);
		add_text(":\n-- ");
		send_image(1'b0);
		// Good images: mixed case, all ones, all zeros, extra header after the digest
		add_text("MD5:  0123456789abcdefABCDEF0123456789\nkey: value\n--\nhi");
		image.push_back(CH_NUL);
		send_image(1'b0);
		add_text("MD5:ffffffffffffffffFFFFFFFFFFFFFFFF\n--\n");
		image.push_back(8'hA5);
		send_image(1'b1);
		add_text("MD5:00000000000000000000000000000000\n--\nz");
		send_image(1'b0);
		// Zero byte ends the value; rest of the line is skipped
		add_text("MD5:");
		add_hex(32);
		image.push_back(CH_NUL);
		add_text("zz:q\n--\nb");
		send_image(1'b0);
		// Zero byte ends the name
		add_text("MD5");
		image.push_back(CH_NUL);
		add_text("x:");
		add_hex(32);
		add_text("\n--\nb");
		send_image(1'b0);
		// Second digest header, bad digit, short and saturated lengths
		add_text("MD5:");
		add_hex(32);
		add_text("\nMD5:");
		add_hex(32);
		add_text("\n--\nb");
		send_image(1'b0);
		add_text("MD5:0123456789abcdeg0123456789abcdef\n--\nb");
		send_image(1'b0);
		add_text("MD5:");
		add_hex(31);
		add_text("\n--\nb");
		send_image(1'b0);
		add_text("MD5:");
		add_hex(40);
		add_text("\n--\nb");
		send_image(1'b0);
		// Near-miss names and partial delimiters are ordinary headers
		add_text("MD:x\nMD55:");
		add_hex(32);
		add_text("\n--x:1\n--:2\n-:3\nMD5:");
		add_hex(32);
		add_text("\n--\nb");
		send_image(1'b0);
		// End of file in the middle of a digest value
		add_text("MD5:01");
		send_image(1'b0);
		// Ignored markers sprinkled through a good image
		marker_pct = 40;
		add_text("MD5:");
		add_hex(32);
		add_text("\n--\nok");
		send_image(1'b1);
		marker_pct = 0;
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		// Hold the output off while a whole image is offered
		hold_req      = HOLD_CYCLES;
		sender_steady = 1'b1;
		add_text("MD5:");
		add_hex(32);
		add_text("\nname: val\n--\n");
		repeat (12) image.push_back(8'($urandom_range(0, 255)));
		send_image(1'b0);
		sender_steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_images();
		int start_items;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			sender_steady = ($urandom_range(0, 3) == 0);
			marker_pct    = ($urandom_range(0, 4) == 0) ? 5 : 0;
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 30)) image.push_back(grammar_byte());
			end else begin
				build_random_image();
			end
			send_image($urandom_range(0, 1));
			if ($urandom_range(0, 5) == 0) begin
				wait_drained();
			end
		end
		sender_steady = 1'b0;
		marker_pct    = 0;
		wait_drained();
	endtask

	initial begin
		clear_parse_state();
		foreach (verdict_tally[i]) verdict_tally[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_images();
		test_output_backpressure();
		test_random_images();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d outputs for %0d bytes in %0d images, with stalls on both sides.",
		         results_checked, items_sent, files_sent);
		$display("Verdicts: %0d good, %0d syntax, %0d no body, %0d digest problem.",
		         verdict_tally[VERDICT_OK], verdict_tally[VERDICT_SYNTAX],
		         verdict_tally[VERDICT_NOBODY], verdict_tally[VERDICT_DIGEST]);
		if (fail_count == 0 && predicted_outputs.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: image_header_parser_top.f
rtl/ihp_pkg.sv
rtl/ihp_parser.sv
rtl/ihp_out_stage.sv
rtl/image_header_parser_top.sv
dv/testbench.sv
